FILE: rtl/prtp_pkg.sv
// Shared types and constants for the port range to prefix block expander.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package prtp_pkg;

    // Port field width and the widths derived from it.
    localparam int PORT_W   = 16;
    localparam int CURSOR_W = PORT_W + 1;
    localparam int EXP_W    = $clog2(PORT_W + 1);

    // One range item as it arrives.
    typedef struct packed {
        logic [PORT_W-1:0] range_low;
        logic [PORT_W-1:0] range_high;
    } prtp_req_t;

    // One prefix block item as it leaves.
    typedef struct packed {
        logic [PORT_W-1:0] block_start;
        logic [PORT_W-1:0] block_end;
        logic [EXP_W-1:0]  prefix_length;
        logic              last_block;
    } prtp_blk_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;  // take a new range into the cursor and bound registers
        logic emit;  // register the current block and advance the cursor
    } prtp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;  // the offered range has its low end above its high end
        logic last;   // the current block reaches the upper bound
    } prtp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/prtp_dp.sv
// Datapath: cursor and bound registers, block size logic and the output register.
// Depends on prtp_pkg; driven by commands from prtp_ctrl.
`default_nettype none

module prtp_dp (
    input  wire logic                  clk,
    input  wire prtp_pkg::prtp_req_t   req,
    input  wire prtp_pkg::prtp_cmd_t   cmd,
    output prtp_pkg::prtp_sts_t        sts,
    output prtp_pkg::prtp_blk_t        blk
);
    import prtp_pkg::*;

    logic [CURSOR_W-1:0] cursor_reg, cursor_next;
    logic [PORT_W-1:0]   upper_reg, upper_next;
    prtp_blk_t           blk_reg, blk_next;

    logic [CURSOR_W-1:0] span;
    logic [EXP_W-1:0]    size_exp;
    logic [EXP_W-1:0]    align_exp;
    logic [EXP_W-1:0]    blk_exp;
    logic [CURSOR_W-1:0] end_pos;

    // Number of values left from the cursor up to the bound, inclusive.
    assign span = {1'b0, upper_reg} - cursor_reg + CURSOR_W'(1);

    // Largest power of two that fits in the remaining span.
    always_comb
    begin
        size_exp = '0;
        for (int i = 0; i < CURSOR_W; i++)
        begin
            if (span[i])
            begin
                size_exp = EXP_W'(i);
            end
        end
    end

    // Alignment of the cursor: its count of trailing zeros, full width when zero.
    always_comb
    begin
        align_exp = EXP_W'(PORT_W);
        for (int i = PORT_W - 1; i >= 0; i--)
        begin
            if (cursor_reg[i])
            begin
                align_exp = EXP_W'(i);
            end
        end
    end

    // The block is bounded by both alignment and remaining span.
    assign blk_exp = (align_exp < size_exp) ? align_exp : size_exp;
    assign end_pos = cursor_reg + ((CURSOR_W'(1) << blk_exp) - CURSOR_W'(1));

    assign sts.empty = req.range_low > req.range_high;
    assign sts.last  = end_pos[PORT_W-1:0] == upper_reg;

    // Next values of the cursor, the bound and the output register.
    always_comb
    begin
        cursor_next = cursor_reg;
        upper_next  = upper_reg;
        blk_next    = blk_reg;
        if (cmd.load)
        begin
            cursor_next = {1'b0, req.range_low};
            upper_next  = req.range_high;
        end
        if (cmd.emit)
        begin
            cursor_next            = end_pos + CURSOR_W'(1);
            blk_next.block_start   = cursor_reg[PORT_W-1:0];
            blk_next.block_end     = end_pos[PORT_W-1:0];
            blk_next.prefix_length = EXP_W'(PORT_W) - blk_exp;
            blk_next.last_block    = sts.last;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        upper_reg  <= upper_next;
        blk_reg    <= blk_next;
    end

    assign blk = blk_reg;

endmodule

`default_nettype wire

FILE: rtl/prtp_ctrl.sv
// Controller: state machine that sequences one range into its run of blocks.
// Depends on prtp_pkg; commands prtp_dp and owns both handshakes.
`default_nettype none

module prtp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    output logic                     blk_valid,
    input  wire logic                blk_ready,
    input  wire prtp_pkg::prtp_sts_t sts,
    output prtp_pkg::prtp_cmd_t      cmd
);
    import prtp_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   blk_valid_reg, blk_valid_next;
    logic   out_free;

    // The output register can take a block when empty or being drained.
    assign out_free = !blk_valid_reg || blk_ready;

    assign req_ready = state_reg == ST_IDLE;
    assign cmd.load  = (state_reg == ST_IDLE) && req_valid;
    assign cmd.emit  = (state_reg == ST_RUN) && out_free;

    // Next state and next output valid.
    always_comb
    begin
        state_next     = state_reg;
        blk_valid_next = blk_valid_reg;
        if (blk_ready)
        begin
            blk_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && !sts.empty)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (out_free)
                begin
                    blk_valid_next = 1'b1;
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    assign blk_valid = blk_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/port_range_to_prefixes.sv
// Top level of the port range to prefix block expander.
// Depends on prtp_pkg, prtp_ctrl and prtp_dp.
//
// Takes an inclusive 16-bit range (range_low .. range_high) and returns, in
// ascending order, the fewest aligned power-of-two blocks that cover it, one
// block item per cycle while the output side takes them. Each range is first
// loaded into the cursor and bound registers, then its blocks are emitted in
// turn (a run is at most 30 blocks). A range with its low end above its high
// end is taken and yields no block. The next range is taken as soon as the
// last block of a run has entered the output register.
`default_nettype none

module port_range_to_prefixes (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire prtp_pkg::prtp_req_t req,
    output logic                     blk_valid,
    input  wire logic                blk_ready,
    output prtp_pkg::prtp_blk_t      blk
);
    import prtp_pkg::*;

    prtp_cmd_t cmd;
    prtp_sts_t sts;

    // Sequencing and handshakes.
    prtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Cursor, block sizing and output payload.
    prtp_dp u_dp (
        .clk (clk),
        .req (req),
        .cmd (cmd),
        .sts (sts),
        .blk (blk)
    );

endmodule

`default_nettype wire
